### design/srubs_pkg.sv
package srubs_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 1024;
  localparam int RANK_BITS_DEFAULT   = 32;

  // operation codes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_FOUND    = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_INVALID  = 2'd2;

  typedef struct packed {
    logic        operation;
    logic [9:0]  table_address;
    logic [31:0] table_word;
    logic [4:0]  grid_width;
    logic [3:0]  outer_row;
    logic [31:0] query_rank;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  sector_number;
    logic [31:0] begin_rank;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_PROBE
  } state_t;

  // first table entry of each width group, indexed by (W - 8) / 2
  function automatic logic [9:0] width_start(input logic [3:0] idx);
    logic [9:0] v;
    unique case (idx)
      4'd0:    v = 10'd0;
      4'd1:    v = 10'd10;
      4'd2:    v = 10'd25;
      4'd3:    v = 10'd46;
      4'd4:    v = 10'd74;
      4'd5:    v = 10'd110;
      4'd6:    v = 10'd155;
      4'd7:    v = 10'd210;
      4'd8:    v = 10'd276;
      4'd9:    v = 10'd354;
      4'd10:   v = 10'd445;
      default: v = 10'd0;
    endcase
    return v;
  endfunction

endpackage

### design/sector_rank_upper_bound_search.sv
// Table write: accepted while idle, busy stays low, no result beat.
// Search: a setup state (row base, slot count) then upper-bound probe steps on the
// single table read port, with busy high throughout (setup only for a bad width/row).
// Result beat strobes in the first cycle busy is low; the next start can be
// taken in that cycle, at the edge that ends that beat.
// Receiver cannot stall. Sync active-high reset idles the sequencer; table undefined.
module sector_rank_upper_bound_search #(
  parameter int TABLE_DEPTH = srubs_pkg::TABLE_DEPTH_DEFAULT,
  parameter int RANK_BITS   = srubs_pkg::RANK_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  srubs_pkg::item_t   item,
  output logic               strobe,
  output srubs_pkg::result_t result
);

  localparam int ADDR_BITS = $clog2(TABLE_DEPTH);

  // end rank table, one write port, one registered read port
  logic [RANK_BITS-1:0] mem [TABLE_DEPTH];
  logic [RANK_BITS-1:0] rd_data;
  logic [ADDR_BITS-1:0] rd_addr;
  logic                 rd_en;

  srubs_pkg::state_t state, state_next;

  // captured search item
  logic [4:0]           width;
  logic [3:0]           row;
  logic [RANK_BITS-1:0] rank;

  // search window and carried begin rank
  logic [9:0]           base;
  logic [3:0]           count;
  logic [3:0]           lo;
  logic [3:0]           hi;
  logic [3:0]           mid;
  logic [RANK_BITS-1:0] carry;

  logic accept;
  logic wr_en;

  // setup arithmetic
  logic       setup_ok;
  logic [3:0] half;
  logic [4:0] slots_l;
  logic [2:0] even_slots;
  logic [3:0] odd_slots;
  logic [3:0] row_up;
  logic [6:0] prod_even;
  logic [6:0] prod_odd;
  logic [9:0] setup_base;
  logic [3:0] setup_count;
  logic [3:0] setup_mid;

  // probe step
  logic                 probe_less;
  logic [3:0]           lo_next;
  logic [3:0]           hi_next;
  logic [3:0]           mid_next;
  logic [RANK_BITS-1:0] carry_next;
  logic                 probe_more;

  logic               finish;
  srubs_pkg::result_t result_next;

  assign busy   = (state != srubs_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign wr_en  = accept && (item.operation == srubs_pkg::OP_WRITE) &&
                  (32'(item.table_address) < TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[ADDR_BITS'(item.table_address)] <= RANK_BITS'(item.table_word);
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // setup: validate width/row, locate the row and size its slot window
  always_comb begin
    half        = width[4:1];
    setup_ok    = (width >= 5'd8) && (width <= 5'd28) && !width[0] && (row < half);
    slots_l     = 5'(half) + 5'd1;
    even_slots  = slots_l[3:1];
    odd_slots   = 4'((slots_l + 5'd1) >> 1);
    row_up      = 4'((5'(row) + 5'd1) >> 1);
    prod_even   = 7'(row_up) * 7'(even_slots);
    prod_odd    = 7'(row[3:1]) * 7'(odd_slots);
    setup_base  = srubs_pkg::width_start(4'((width - 5'd8) >> 1)) +
                  10'(prod_even) + 10'(prod_odd);
    setup_count = row[0] ? odd_slots : 4'(even_slots);
    setup_mid   = setup_count >> 1;
  end

  // probe: one upper-bound step on the entry read last cycle
  always_comb begin
    probe_less = rank < rd_data;
    lo_next    = lo;
    hi_next    = hi;
    carry_next = carry;
    if (probe_less) begin
      hi_next = mid;
    end else begin
      lo_next    = mid + 4'd1;
      carry_next = rd_data;
    end
    mid_next   = lo_next + ((hi_next - lo_next) >> 1);
    probe_more = lo_next < hi_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      srubs_pkg::ST_IDLE: begin
        if (accept && item.operation == srubs_pkg::OP_SEARCH) begin
          state_next = srubs_pkg::ST_SETUP;
        end
      end
      srubs_pkg::ST_SETUP: begin
        state_next = setup_ok ? srubs_pkg::ST_PROBE : srubs_pkg::ST_IDLE;
      end
      srubs_pkg::ST_PROBE: begin
        if (!probe_more) begin
          state_next = srubs_pkg::ST_IDLE;
        end
      end
      default: state_next = srubs_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: read port control and the finished result
  always_comb begin
    rd_en       = 1'b0;
    rd_addr     = ADDR_BITS'(setup_base + 10'(setup_mid));
    finish      = 1'b0;
    result_next = '{status: srubs_pkg::STATUS_INVALID, sector_number: 4'd0,
                    begin_rank: 32'd0};
    unique case (state)
      srubs_pkg::ST_IDLE: begin
      end
      srubs_pkg::ST_SETUP: begin
        rd_en  = setup_ok;
        finish = !setup_ok;
      end
      srubs_pkg::ST_PROBE: begin
        rd_en   = probe_more;
        rd_addr = ADDR_BITS'(base + 10'(mid_next));
        finish  = !probe_more;
        if (lo_next < count) begin
          result_next.status        = srubs_pkg::STATUS_FOUND;
          result_next.sector_number = 4'({lo_next, 1'b0}) + {3'd0, !row[0]};
          result_next.begin_rank    = 32'(carry_next);
        end else begin
          result_next.status = srubs_pkg::STATUS_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= srubs_pkg::ST_IDLE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      width <= item.grid_width;
      row   <= item.outer_row;
      rank  <= RANK_BITS'(item.query_rank);
    end
    if (state == srubs_pkg::ST_SETUP) begin
      base  <= setup_base;
      count <= setup_count;
      lo    <= 4'd0;
      hi    <= setup_count;
      mid   <= setup_mid;
      carry <= '0;
    end else if (state == srubs_pkg::ST_PROBE) begin
      lo    <= lo_next;
      hi    <= hi_next;
      mid   <= mid_next;
      carry <= carry_next;
    end
    if (finish) begin
      result <= result_next;
    end
  end

endmodule

### verif/sector_rank_upper_bound_search_test.sv
`timescale 1ns / 100ps

module sector_rank_upper_bound_search_test;

  localparam int unsigned RANDOM_BEATS = 850;

  // first table entry of each width group, index (W - 8) / 2
  localparam int unsigned GROUP_BASE [11] = '{0, 10, 25, 46, 74, 110, 155, 210, 276, 354, 445};

  localparam srubs_pkg::result_t R_INVALID   = '{srubs_pkg::STATUS_INVALID, 4'd0, 32'd0};
  localparam srubs_pkg::result_t R_NOT_FOUND = '{srubs_pkg::STATUS_NOT_FOUND, 4'd0, 32'd0};

  typedef struct {
    srubs_pkg::item_t   beat;
    bit                 typed;   // want holds a hand-written result
    srubs_pkg::result_t want;
  } vector_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  srubs_pkg::item_t   item;
  logic               strobe;
  srubs_pkg::result_t result;

  logic [31:0]        rank_mirror [0:1023];
  srubs_pkg::result_t pending_results [$];
  vector_t            directed_vecs [$];
  int unsigned        mismatch_count;
  bit                 steady;   // no hold-offs on the send side while set

  sector_rank_upper_bound_search u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .strobe (strobe),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop well past the slowest correct run
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // row geometry: L = W/2 + 1, even rows hold L/2 slots, odd rows (L+1)/2
  function automatic int unsigned row_slots(input int unsigned w, input int unsigned row);
    int unsigned l;
    l = w / 2 + 1;
    return (row % 2 == 1) ? (l + 1) / 2 : l / 2;
  endfunction

  function automatic int unsigned slot_origin(input int unsigned w, input int unsigned row);
    int unsigned l;
    l = w / 2 + 1;
    return GROUP_BASE[(w - 8) / 2] + ((row + 1) / 2) * (l / 2) + (row / 2) * ((l + 1) / 2);
  endfunction

  // expected result of one search beat, from the mirrored table
  function automatic srubs_pkg::result_t rank_lookup(input srubs_pkg::item_t beat);
    srubs_pkg::result_t r;
    int unsigned        w, row, count, base, lo, hi, mid;
    logic [31:0]        carry, e;
    r   = R_INVALID;
    w   = 32'(beat.grid_width);
    row = 32'(beat.outer_row);
    if (w < 8 || w > 28 || w % 2 == 1) return r;
    if (row > w / 2 - 1) return r;
    count = row_slots(w, row);
    base  = slot_origin(w, row);
    lo    = 0;
    hi    = count;
    carry = '0;
    // upper bound: first slot whose end exceeds the rank
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      e   = rank_mirror[base + mid];
      if (beat.query_rank < e) begin
        hi = mid;
      end else begin
        lo    = mid + 1;
        carry = e;
      end
    end
    if (lo >= count) return R_NOT_FOUND;
    r.status        = srubs_pkg::STATUS_FOUND;
    r.sector_number = 4'(((row % 2 == 1) ? 0 : 1) + 2 * lo);
    r.begin_rank    = carry;
    return r;
  endfunction

  // unused fields carry random bits so every input bit toggles
  function automatic srubs_pkg::item_t write_beat(input logic [9:0] addr,
                                                  input logic [31:0] word);
    srubs_pkg::item_t b;
    logic [95:0]      fill;
    fill            = {$urandom, $urandom, $urandom};
    b               = fill[$bits(srubs_pkg::item_t)-1:0];
    b.operation     = srubs_pkg::OP_WRITE;
    b.table_address = addr;
    b.table_word    = word;
    return b;
  endfunction

  function automatic srubs_pkg::item_t search_beat(input logic [4:0] w, input logic [3:0] row,
                                                   input logic [31:0] rank);
    srubs_pkg::item_t b;
    logic [95:0]      fill;
    fill          = {$urandom, $urandom, $urandom};
    b             = fill[$bits(srubs_pkg::item_t)-1:0];
    b.operation   = srubs_pkg::OP_SEARCH;
    b.grid_width  = w;
    b.outer_row   = row;
    b.query_rank  = rank;
    return b;
  endfunction

  function automatic srubs_pkg::result_t hit(input logic [3:0] sector, input logic [31:0] b);
    return '{srubs_pkg::STATUS_FOUND, sector, b};
  endfunction

  // one beat: optional hold-off, then hold start until busy is low at an edge
  task automatic drive_beat(input srubs_pkg::item_t beat, input bit typed,
                            input srubs_pkg::result_t want);
    if (!steady && $urandom_range(0, 99) < 16) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    item  <= beat;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if (beat.operation == srubs_pkg::OP_WRITE) rank_mirror[beat.table_address] = beat.table_word;
    else pending_results.push_back(typed ? want : rank_lookup(beat));
  endtask

  // refill one row with non-decreasing ends; zero steps give equal ends
  task automatic load_row(input int unsigned w, input int unsigned row);
    int unsigned base, n, max_step;
    logic [31:0] v;
    base = slot_origin(w, row);
    n    = row_slots(w, row);
    case ($urandom_range(0, 2))
      0: begin
        max_step = 4;
        v        = $urandom_range(0, 8);
      end
      1: begin
        max_step = 1000;
        v        = $urandom_range(0, 100000);
      end
      default: begin
        max_step = 32'h1000_0000;
        v        = $urandom_range(0, 32'h7FFF_FFFF);
      end
    endcase
    for (int unsigned s = 0; s < n; s++) begin
      drive_beat(write_beat(10'(base + s), v), 1'b0, R_INVALID);
      v = v + $urandom_range(0, max_step);
    end
  endtask

  // rank at or next to a stored end of the row, or random, zero or all ones, so that boundaries are hit often
  function automatic logic [31:0] pick_rank(input int unsigned w, input int unsigned row);
    logic [31:0] e;
    e = rank_mirror[slot_origin(w, row) + $urandom_range(0, row_slots(w, row) - 1)];
    case ($urandom_range(0, 5))
      0:       return e;
      1:       return e - 1;
      2:       return e + 1;
      3:       return $urandom;
      4:       return '0;
      default: return '1;
    endcase
  endfunction

  // result checker: the receiver cannot stall, so every strobe is one beat
  always @(posedge clk) begin
    srubs_pkg::result_t want;
    if (!rst && strobe) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result beat with nothing pending: %p", result));
      end else begin
        want = pending_results.pop_front();
        if (result.status !== want.status)
          flag_mismatch($sformatf("status %0d, want %0d", result.status, want.status));
        if (result.sector_number !== want.sector_number)
          flag_mismatch($sformatf("sector_number %0d, want %0d",
                                  result.sector_number, want.sector_number));
        if (result.begin_rank !== want.begin_rank)
          flag_mismatch($sformatf("begin_rank %h, want %h", result.begin_rank, want.begin_rank));
      end
    end
  end

  initial begin
    int unsigned w, row, sel;
    mismatch_count = 0;
    steady         = 1'b0;
    rst   <= 1'b1;
    start <= 1'b0;
    item  <= '0;

    // directed: invalid widths and rows need no table contents
    directed_vecs.push_back('{search_beat(5'd7, 4'd0, 32'd0), 1'b1, R_INVALID});
    directed_vecs.push_back('{search_beat(5'd0, 4'd0, 32'd5), 1'b1, R_INVALID});
    directed_vecs.push_back('{search_beat(5'd6, 4'd1, 32'd5), 1'b1, R_INVALID});
    directed_vecs.push_back('{search_beat(5'd30, 4'd0, 32'd5), 1'b1, R_INVALID});
    directed_vecs.push_back('{search_beat(5'd31, 4'd15, '1), 1'b1, R_INVALID});
    directed_vecs.push_back('{search_beat(5'd8, 4'd4, 32'd0), 1'b1, R_INVALID});
    directed_vecs.push_back('{search_beat(5'd28, 4'd14, '1), 1'b1, R_INVALID});
    // W=8 row 0: two slots at 0 and 1, even row so sector = 1 + 2*slot
    directed_vecs.push_back('{write_beat(10'd0, 32'd100), 1'b1, R_INVALID});
    directed_vecs.push_back('{write_beat(10'd1, 32'hFFFF_FFFF), 1'b1, R_INVALID});
    directed_vecs.push_back('{search_beat(5'd8, 4'd0, 32'd0), 1'b1, hit(4'd1, 32'd0)});
    directed_vecs.push_back('{search_beat(5'd8, 4'd0, 32'd99), 1'b1, hit(4'd1, 32'd0)});
    directed_vecs.push_back('{search_beat(5'd8, 4'd0, 32'd100), 1'b1, hit(4'd3, 32'd100)});
    directed_vecs.push_back('{search_beat(5'd8, 4'd0, 32'hFFFF_FFFE), 1'b1,
                              hit(4'd3, 32'd100)});
    directed_vecs.push_back('{search_beat(5'd8, 4'd0, 32'hFFFF_FFFF), 1'b1, R_NOT_FOUND});
    // top address of the table
    directed_vecs.push_back('{write_beat(10'd1023, 32'h5A5A_A5A5), 1'b1, R_INVALID});
    // W=8 row 1: three slots at 2..4, odd row so sector = 2*slot
    directed_vecs.push_back('{write_beat(10'd2, 32'd10), 1'b1, R_INVALID});
    directed_vecs.push_back('{write_beat(10'd3, 32'd20), 1'b1, R_INVALID});
    directed_vecs.push_back('{write_beat(10'd4, 32'd30), 1'b1, R_INVALID});
    directed_vecs.push_back('{search_beat(5'd8, 4'd1, 32'd25), 1'b0, R_INVALID});
    directed_vecs.push_back('{search_beat(5'd8, 4'd1, 32'd5), 1'b0, R_INVALID});
    directed_vecs.push_back('{search_beat(5'd8, 4'd1, 32'd30), 1'b0, R_INVALID});

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_vecs[i])
      drive_beat(directed_vecs[i].beat, directed_vecs[i].typed, directed_vecs[i].want);

    // fill every row of every width group: entries 0 to 549
    for (w = 8; w <= 28; w += 2)
      for (row = 0; row < w / 2; row++) load_row(w, row);

    for (int unsigned i = 0; i < RANDOM_BEATS; i++) begin
      steady = (i >= 300 && i < 550);
      sel    = $urandom_range(0, 99);
      w      = 8 + 2 * $urandom_range(0, 10);
      row    = $urandom_range(0, w / 2 - 1);
      if (sel < 8) begin
        load_row(w, row);
      end else if (sel < 18) begin
        // stray write; may break a row's ordering until it is reloaded
        drive_beat(write_beat(10'($urandom), $urandom), 1'b0, R_INVALID);
      end else if (sel < 28) begin
        // all fields random: mostly invalid width or row
        drive_beat(search_beat(5'($urandom), 4'($urandom), $urandom), 1'b0, R_INVALID);
      end else begin
        drive_beat(search_beat(5'(w), 4'(row), pick_rank(w, row)), 1'b0, R_INVALID);
      end
    end
    start <= 1'b0;
    steady = 1'b0;

    // drain: wait for every pending result to arrive
    for (int n = 0; n < 200 && pending_results.size() != 0; n++) @(posedge clk);
    if (pending_results.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    repeat (10) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sector_rank_upper_bound_search.f
design/srubs_pkg.sv
design/sector_rank_upper_bound_search.sv
verif/sector_rank_upper_bound_search_test.sv
